[rtl/block_average_audio_compressor_assert.svh]
// Assertion macros for the block-average audio compressor.
// Used by the top level only; no other dependencies.
`ifndef BLOCK_AVERAGE_AUDIO_COMPRESSOR_ASSERT_SVH
`define BLOCK_AVERAGE_AUDIO_COMPRESSOR_ASSERT_SVH
// Same-cycle implication.
`define BAC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication.
`define BAC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

[rtl/bac_pkg.sv]
// Shared types and constants for the block-average audio compressor.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bac_pkg;

   localparam int WINDOW_LOG2 = 8;
   localparam int SAMPLE_W    = 16;
   localparam int MAG_W       = 16;
   localparam int SUM_W       = MAG_W + WINDOW_LOG2;
   localparam int MEAN_W      = 16;
   localparam int LEVEL_W     = 15;
   localparam int GAIN_W      = 17;
   localparam int MIX_W       = 9;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 17;
   localparam int DIV_STEPS   = GAIN_W;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

   localparam logic [GAIN_W-1:0]    UNITY_GAIN   = 17'd65536;
   localparam logic [LEVEL_W-1:0]   LOW_RESET    = 15'd0;
   localparam logic [LEVEL_W-1:0]   HIGH_RESET   = 15'd16536;
   localparam logic [MIX_W-1:0]     FADE_RESET   = 9'd1;
   localparam logic [MIX_W-1:0]     WET_RESET    = 9'd0;
   localparam logic [MIX_W-1:0]     MIX_FULL     = 9'd256;
   localparam logic [DIV_CNT_W-1:0] DIV_LAST     = DIV_CNT_W'(DIV_STEPS - 1);
   localparam logic signed [17:0]   SAMPLE_MAX   = 18'sd32767;
   localparam logic signed [17:0]   SAMPLE_MIN   = -18'sd32768;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LOW_LEVEL   = 3'd0,
      CSR_HIGH_LEVEL  = 3'd1,
      CSR_GAIN_AT_MAX = 3'd2,
      CSR_FADE_STEP   = 3'd3,
      CSR_WET_MIX     = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic capture;
      logic accum;
      logic div_prep;
      logic div_load;
      logic div_step;
      logic div_store;
      logic fade;
      logic scale;
      logic sat;
      logic mix;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic need_div;
   } status_type;

endpackage
`default_nettype wire

[rtl/block_average_audio_compressor.sv]
// Block-average audio compressor: one signed 16-bit sample in, one out.
// Each sample passes the controller's sequence of steps through the accumulator,
// gain fade, gain multiply, saturation and wet/dry multiply before the next sample
// can be accepted; the final step waits until the output register is free. The
// sample that closes a 256-sample window with a mean between the two levels
// also passes the divider, which produces one quotient bit per cycle.
// A finished sample waits in the output register while the next one is taken.
// Depends on bac_pkg, bac_ctrl, bac_dp and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "block_average_audio_compressor_assert.svh"
module block_average_audio_compressor
   import bac_pkg::*;
(
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic signed [SAMPLE_W-1:0]  req_sample_in,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic signed [SAMPLE_W-1:0]       rsp_sample_out,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [CSR_IDX_W-1:0]        csr_index,
   input  wire logic [CSR_DATA_W-1:0]       csr_wdata
);

   cmd_type                     cmd;
   status_type                  status;
   logic signed [SAMPLE_W-1:0]  result;
   logic                        out_free;
   logic                        rsp_valid_ff;
   logic signed [SAMPLE_W-1:0]  rsp_data_ff;

   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   bac_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .out_free  (out_free),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   bac_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sample_in (req_sample_in),
      .csr_we    (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .status    (status),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_data_ff;

   `BAC_ASSERT_NEXT(a_accept_busy, clock, reset, req_valid && !req_stall, req_stall, "accepted transaction did not make the block busy")
   `BAC_ASSERT_SAME(a_load_free, clock, reset, cmd.load_out, !rsp_valid || !rsp_stall, "output register overwritten while stalled")
   `BAC_ASSERT_NEXT(a_load_shown, clock, reset, cmd.load_out, rsp_valid, "loaded result not presented")

endmodule
`default_nettype wire

[rtl/bac_ctrl.sv]
// Sequencing controller for the block-average audio compressor.
// Depends on bac_pkg for the command and status types.
`timescale 1ns / 1ps
`default_nettype none
module bac_ctrl
   import bac_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire status_type status,
   input  wire logic       out_free,
   output logic            req_stall,
   output cmd_type         cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ACCUM,
      ST_DIV_PREP,
      ST_DIV_LOAD,
      ST_DIV_RUN,
      ST_DIV_STORE,
      ST_FADE,
      ST_SCALE,
      ST_SAT,
      ST_MIX,
      ST_SUM
   } state_type;

   state_type             state_ff, state_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                  stall_ff, stall_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      stall_in = stall_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_ACCUM;
               stall_in = 1'b1;
            end
         end
         ST_ACCUM: begin
            state_in = status.need_div ? ST_DIV_PREP : ST_FADE;
         end
         ST_DIV_PREP: state_in = ST_DIV_LOAD;
         ST_DIV_LOAD: begin
            state_in = ST_DIV_RUN;
            cnt_in   = '0;
         end
         ST_DIV_RUN: begin
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_DIV_STORE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DIV_STORE: state_in = ST_FADE;
         ST_FADE:      state_in = ST_SCALE;
         ST_SCALE:     state_in = ST_SAT;
         ST_SAT:       state_in = ST_MIX;
         ST_MIX:       state_in = ST_SUM;
         ST_SUM: begin
            if (out_free) begin
               state_in = ST_IDLE;
               stall_in = 1'b0;
            end
         end
         default: begin
            state_in = ST_IDLE;
            stall_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         stall_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         stall_ff <= stall_in;
      end
   end

   assign req_stall = stall_ff;

   always_comb begin
      cmd           = '0;
      cmd.capture   = (state_ff == ST_IDLE) && req_valid;
      cmd.accum     = (state_ff == ST_ACCUM);
      cmd.div_prep  = (state_ff == ST_DIV_PREP);
      cmd.div_load  = (state_ff == ST_DIV_LOAD);
      cmd.div_step  = (state_ff == ST_DIV_RUN);
      cmd.div_store = (state_ff == ST_DIV_STORE);
      cmd.fade      = (state_ff == ST_FADE);
      cmd.scale     = (state_ff == ST_SCALE);
      cmd.sat       = (state_ff == ST_SAT);
      cmd.mix       = (state_ff == ST_MIX);
      cmd.load_out  = (state_ff == ST_SUM) && out_free;
   end

endmodule
`default_nettype wire

[rtl/bac_dp.sv]
// Datapath of the block-average audio compressor: configuration registers,
// window accumulator, target divider, gain fade, scaling and wet/dry mix.
// Depends on bac_pkg for types and constants.
`timescale 1ns / 1ps
`default_nettype none
module bac_dp
   import bac_pkg::*;
(
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire cmd_type                      cmd,
   input  wire logic signed [SAMPLE_W-1:0]   sample_in,
   input  wire logic                         csr_we,
   input  wire logic [CSR_IDX_W-1:0]         csr_index,
   input  wire logic [CSR_DATA_W-1:0]        csr_wdata,
   output status_type                        status,
   output logic signed [SAMPLE_W-1:0]        result
);

   logic [LEVEL_W-1:0]          low_ff, high_ff;
   logic [GAIN_W-1:0]           gam_ff;
   logic [MIX_W-1:0]            fade_ff, wet_ff;

   logic signed [SAMPLE_W-1:0]  samp_ff;
   logic [SUM_W-1:0]            sum_ff;
   logic [WINDOW_LOG2-1:0]      count_ff;
   logic [GAIN_W-1:0]           cur_ff, tgt_ff;
   logic [MEAN_W-1:0]           mean_ff;
   logic [LEVEL_W-1:0]          span_ff, rest_ff;
   logic [31:0]                 part_ff;
   logic [LEVEL_W-1:0]          rem_ff;
   logic [GAIN_W-1:0]           quo_ff;
   logic signed [33:0]          prod_ff;
   logic signed [SAMPLE_W-1:0]  scaled_ff;
   logic signed [25:0]          dry_ff, wet_prod_ff;

   logic [MAG_W-1:0]            mag;
   logic [SUM_W-1:0]            sum_next;
   logic [MEAN_W-1:0]           mean;
   logic                        win_end, below_low, at_high;
   logic [LEVEL_W-1:0]          pos;
   logic [32:0]                 num;
   logic [LEVEL_W:0]            div_part;
   logic                        div_ge;
   logic [GAIN_W:0]             gain_up;
   logic [GAIN_W-1:0]           gain_diff, gain_next;
   logic signed [33:0]          prod_adj;
   logic signed [17:0]          quot;
   logic signed [SAMPLE_W-1:0]  sat_val;
   logic [MIX_W-1:0]            wet_eff, dry_eff;
   logic signed [26:0]          mix_sum, mix_adj;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff  <= LOW_RESET;
         high_ff <= HIGH_RESET;
         gam_ff  <= UNITY_GAIN;
         fade_ff <= FADE_RESET;
         wet_ff  <= WET_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_LOW_LEVEL:   low_ff  <= csr_wdata[LEVEL_W-1:0];
            CSR_HIGH_LEVEL:  high_ff <= csr_wdata[LEVEL_W-1:0];
            CSR_GAIN_AT_MAX: gam_ff  <= csr_wdata[GAIN_W-1:0];
            CSR_FADE_STEP:   fade_ff <= csr_wdata[MIX_W-1:0];
            CSR_WET_MIX:     wet_ff  <= csr_wdata[MIX_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      mag       = samp_ff[SAMPLE_W-1] ? MAG_W'(-samp_ff) : MAG_W'(samp_ff);
      sum_next  = sum_ff + SUM_W'(mag);
      mean      = sum_next[SUM_W-1:WINDOW_LOG2];
      win_end   = (count_ff == '1);
      below_low = (mean < MEAN_W'(low_ff));
      at_high   = (mean >= MEAN_W'(high_ff));
      status.need_div = win_end && !below_low && !at_high;

      pos = mean_ff[LEVEL_W-1:0] - low_ff;
      num = 33'({rest_ff, 16'd0}) + 33'(part_ff);

      div_part = {rem_ff, quo_ff[GAIN_W-1]};
      div_ge   = (div_part >= (LEVEL_W+1)'(span_ff));

      gain_up   = (GAIN_W+1)'(cur_ff) + (GAIN_W+1)'(fade_ff);
      gain_diff = cur_ff - tgt_ff;
      gain_next = cur_ff;
      if (cur_ff < tgt_ff) begin
         gain_next = (gain_up > (GAIN_W+1)'(tgt_ff)) ? tgt_ff : gain_up[GAIN_W-1:0];
      end else if (cur_ff > tgt_ff) begin
         gain_next = (gain_diff <= GAIN_W'(fade_ff)) ? tgt_ff :
                     cur_ff - GAIN_W'(fade_ff);
      end

      prod_adj = prod_ff + (prod_ff[33] ? 34'sd65535 : 34'sd0);
      quot     = prod_adj[33:16];
      if (quot > SAMPLE_MAX) begin
         sat_val = SAMPLE_W'(SAMPLE_MAX);
      end else if (quot < SAMPLE_MIN) begin
         sat_val = SAMPLE_W'(SAMPLE_MIN);
      end else begin
         sat_val = quot[SAMPLE_W-1:0];
      end

      wet_eff = (wet_ff > MIX_FULL) ? MIX_FULL : wet_ff;
      dry_eff = MIX_FULL - wet_eff;

      mix_sum = 27'(dry_ff) + 27'(wet_prod_ff);
      mix_adj = mix_sum + (mix_sum[26] ? 27'sd255 : 27'sd0);
      result  = mix_adj[23:8];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         count_ff <= '0;
         cur_ff   <= UNITY_GAIN;
         tgt_ff   <= UNITY_GAIN;
      end else begin
         if (cmd.accum) begin
            if (win_end) begin
               sum_ff   <= '0;
               count_ff <= '0;
               if (below_low) begin
                  tgt_ff <= UNITY_GAIN;
               end else if (at_high) begin
                  tgt_ff <= gam_ff;
               end
            end else begin
               sum_ff   <= sum_next;
               count_ff <= count_ff + 1'b1;
            end
         end
         if (cmd.div_store) begin
            tgt_ff <= quo_ff;
         end
         if (cmd.fade) begin
            cur_ff <= gain_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         samp_ff <= sample_in;
      end
      if (cmd.accum) begin
         mean_ff <= mean;
      end
      if (cmd.div_prep) begin
         span_ff <= high_ff - low_ff;
         rest_ff <= (high_ff - low_ff) - pos;
         part_ff <= 32'(gam_ff) * 32'(pos);
      end
      if (cmd.div_load) begin
         rem_ff <= num[31:17];
         quo_ff <= num[16:0];
      end
      if (cmd.div_step) begin
         rem_ff <= div_ge ? LEVEL_W'(div_part - (LEVEL_W+1)'(span_ff)) :
                   div_part[LEVEL_W-1:0];
         quo_ff <= {quo_ff[GAIN_W-2:0], div_ge};
      end
      if (cmd.scale) begin
         prod_ff <= 34'(samp_ff) * 34'($signed({1'b0, cur_ff}));
      end
      if (cmd.sat) begin
         scaled_ff <= sat_val;
      end
      if (cmd.mix) begin
         dry_ff      <= 26'(samp_ff) * 26'($signed({1'b0, dry_eff}));
         wet_prod_ff <= 26'(scaled_ff) * 26'($signed({1'b0, wet_eff}));
      end
   end

endmodule
`default_nettype wire

[tb/block_average_audio_compressor_checker.sv]
`timescale 1ns / 1ps
// Output checker for the block-average audio compressor: follows register writes,
// predicts every output sample and compares each response transaction in order.
// Depends on bac_pkg only.
module block_average_audio_compressor_checker
   import bac_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic signed [SAMPLE_W-1:0] req_sample_in,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic signed [SAMPLE_W-1:0] rsp_sample_out,
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_wdata,
   output int                         error_count,
   output int                         pending_results
);

   logic [LEVEL_W-1:0]         lvl_low;
   logic [LEVEL_W-1:0]         lvl_high;
   logic [GAIN_W-1:0]          max_gain;
   logic [MIX_W-1:0]           gain_slew;
   logic [MIX_W-1:0]           wet_share;
   logic [SUM_W-1:0]           level_acc;
   logic [WINDOW_LOG2-1:0]     window_pos;
   logic [GAIN_W-1:0]          gain_now;
   logic [GAIN_W-1:0]          gain_goal;
   logic signed [SAMPLE_W-1:0] predicted_samples[$];
   logic signed [SAMPLE_W-1:0] oldest_sample;
   int                         output_count;

   task automatic report_mismatch(input string msg);
      $display("%0t: output %0d: %s", $time, output_count, msg);
      error_count++;
   endtask

   function automatic logic [GAIN_W-1:0] gain_for_mean(input longint unsigned mean);
      longint unsigned span;
      longint unsigned pos;
      if (mean < lvl_low)
         return UNITY_GAIN;
      if (mean >= lvl_high)
         return max_gain;
      span = lvl_high - lvl_low;
      pos  = mean - lvl_low;
      return GAIN_W'((longint'(UNITY_GAIN) * (span - pos) + max_gain * pos) / span);
   endfunction

   // Advances the window and the gain fade by one sample and returns the mixed output.
   function automatic logic signed [SAMPLE_W-1:0] compressed_sample(
      input logic signed [SAMPLE_W-1:0] s);
      longint x;
      longint g;
      longint scaled;
      longint wet;
      longint mixed;
      x = s;
      level_acc = level_acc + SUM_W'(x < 0 ? -x : x);
      if (window_pos == '1) begin
         gain_goal  = gain_for_mean(level_acc >> WINDOW_LOG2);
         level_acc  = '0;
         window_pos = '0;
      end else begin
         window_pos = window_pos + 1'b1;
      end
      g = gain_now;
      if (g < gain_goal) begin
         g = g + gain_slew;
         if (g > gain_goal)
            g = gain_goal;
      end else if (g > gain_goal) begin
         if (g - gain_goal <= gain_slew)
            g = gain_goal;
         else
            g = g - gain_slew;
      end
      gain_now = GAIN_W'(g);
      scaled = (x * g) / longint'(UNITY_GAIN);
      if (scaled > SAMPLE_MAX)
         scaled = SAMPLE_MAX;
      else if (scaled < SAMPLE_MIN)
         scaled = SAMPLE_MIN;
      wet   = (wet_share > MIX_FULL) ? MIX_FULL : wet_share;
      mixed = ((longint'(MIX_FULL) - wet) * x + wet * scaled) / longint'(MIX_FULL);
      return SAMPLE_W'(mixed);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         lvl_low    = LOW_RESET;
         lvl_high   = HIGH_RESET;
         max_gain   = UNITY_GAIN;
         gain_slew  = FADE_RESET;
         wet_share  = WET_RESET;
         level_acc  = '0;
         window_pos = '0;
         gain_now   = UNITY_GAIN;
         gain_goal  = UNITY_GAIN;
         predicted_samples.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_LOW_LEVEL:   lvl_low   = csr_wdata[LEVEL_W-1:0];
               CSR_HIGH_LEVEL:  lvl_high  = csr_wdata[LEVEL_W-1:0];
               CSR_GAIN_AT_MAX: max_gain  = csr_wdata[GAIN_W-1:0];
               CSR_FADE_STEP:   gain_slew = csr_wdata[MIX_W-1:0];
               CSR_WET_MIX:     wet_share = csr_wdata[MIX_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (predicted_samples.size() == 0) begin
               report_mismatch($sformatf("sample_out %0d with no transaction pending",
                                         rsp_sample_out));
            end else begin
               oldest_sample = predicted_samples.pop_front();
               if (rsp_sample_out !== oldest_sample)
                  report_mismatch($sformatf("sample_out %0d, expected %0d",
                                            rsp_sample_out, oldest_sample));
            end
            output_count++;
         end
         if (req_valid && !req_stall)
            predicted_samples.push_back(compressed_sample(req_sample_in));
      end
      pending_results = predicted_samples.size();
   end

endmodule

[tb/block_average_audio_compressor_tb.sv]
`timescale 1ns / 1ps
// Testbench top for the block-average audio compressor: clock, reset, sample and
// register stimulus under several pacing phases, and the final verdict.
// Depends on bac_pkg, the block and block_average_audio_compressor_checker.
module block_average_audio_compressor_tb
   import bac_pkg::*;
;

   localparam int unsigned FULL_RANGE = 65536;
   localparam int          HOLD_CYCLES = 400;
   localparam int          PHASE_ITEMS = 130;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic signed [SAMPLE_W-1:0] req_sample_in = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_sample_out;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_IDX_W-1:0]       csr_index = '0;
   logic [CSR_DATA_W-1:0]      csr_wdata = '0;
   int                         error_count;
   int                         pending_results;
   int                         sender_gap_pct = 0;
   int                         stall_pct = 0;
   int                         samples_sent = 0;
   int                         hold_left = 0;
   logic                       hold_request = 1'b0;
   logic                       hold_done = 1'b0;
   int unsigned                amplitude = 0;

   block_average_audio_compressor dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sample_out (rsp_sample_out),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   block_average_audio_compressor_checker output_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_sample_in   (req_sample_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_sample_out  (rsp_sample_out),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .error_count     (error_count),
      .pending_results (pending_results)
   );

   always #4 clock = ~clock;

   always @(negedge clock) begin
      if (hold_request && !hold_done) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic offer_sample(input logic signed [SAMPLE_W-1:0] value);
      while ($urandom_range(99) < sender_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_sample_in <= value;
      do
         @(posedge clock);
      while (req_stall);
      samples_sent++;
      @(negedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input int unsigned value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      do
         @(posedge clock);
      while (!csr_ready);
      @(negedge clock);
   endtask

   function automatic int unsigned pick_amplitude();
      case ($urandom_range(9))
         0: return $urandom_range(15);
         7: return 32768;
         8: return $urandom_range(32768, 16000);
         9: return FULL_RANGE;
         default: return $urandom_range(32768);
      endcase
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] random_sample(input int unsigned amp);
      int unsigned mag;
      if (amp >= FULL_RANGE)
         return SAMPLE_W'($urandom);
      mag = $urandom_range(amp);
      if ($urandom_range(1))
         return SAMPLE_W'(-int'(mag));
      return SAMPLE_W'((mag > 32767) ? 32767 : mag);
   endfunction

   task automatic drain_outputs();
      req_valid <= 1'b0;
      wait (pending_results == 0);
      @(negedge clock);
   endtask

   // Each new window gets its own amplitude so that window means spread over the levels.
   task automatic run_phase(input int unsigned low, input int unsigned high,
                            input int unsigned gain, input int unsigned slew,
                            input int unsigned wet, input int gap, input int stall,
                            input bit hold);
      write_register(CSR_LOW_LEVEL, low);
      write_register(CSR_HIGH_LEVEL, high);
      write_register(CSR_GAIN_AT_MAX, gain);
      write_register(CSR_FADE_STEP, slew);
      write_register(CSR_WET_MIX, wet);
      csr_valid      <= 1'b0;
      sender_gap_pct = gap;
      stall_pct      = stall;
      if (hold)
         hold_request = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
         if (samples_sent % 256 == 0)
            amplitude = pick_amplitude();
         offer_sample(random_sample(amplitude));
      end
      drain_outputs();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      offer_sample(16'sh7FFF);
      offer_sample(-16'sh8000);
      offer_sample(16'sh0000);
      offer_sample(16'sh0001);
      offer_sample(-16'sh0001);
      offer_sample(16'sh5555);
      offer_sample(-16'sh5556);
      offer_sample(16'sh4000);
      offer_sample(-16'sh7FFF);
      drain_outputs();
      run_phase(0, 16536, 0, 256, 256, 0, 0, 1'b0);
      run_phase(4000, 12000, 32768, 7, 128, 86, 0, 1'b0);
      run_phase(8000, 8000, 131071, 0, 511, 0, 86, 1'b1);
      run_phase(16536, 0, 100, 1, 0, 9, 9, 1'b0);
      run_phase(1000, 16536, 98304, 256, 256, 0, 0, 1'b0);
      run_phase(0, 300, 131071, 64, 300, 86, 86, 1'b0);
      run_phase($urandom_range(16536), $urandom_range(16536), $urandom_range(131071),
                $urandom_range(256, 1), $urandom_range(300), 9, 9, 1'b0);
      repeat (40) @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #(10_000_000);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

[files.f]
+incdir+rtl
rtl/bac_pkg.sv
rtl/bac_ctrl.sv
rtl/bac_dp.sv
rtl/block_average_audio_compressor.sv
tb/block_average_audio_compressor_checker.sv
tb/block_average_audio_compressor_tb.sv
